/* sv/bcs_pkg.sv */
// Shared types and constants of the bad-character skip search core.
package bcs_pkg;

  // Fixed field widths
  localparam int CFG_W  = 7;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 32;

  // Input opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEXT = 1'b1;

  // Result kinds
  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Source of the window advance
  typedef enum logic [1:0] {
    SH_ONE   = 2'd0,  // after a match
    SH_M     = 2'd1,  // full window length
    SH_NEAR  = 2'd2,  // m minus skip table entry
    SH_FOUND = 2'd3   // found by scanning the pattern store
  } shift_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       acc_load;
    logic       acc_text;
    logic       cmp_start;
    logic       srch_start;
    logic       scan_en;
    logic       scan_srch;
    logic       adv;
    shift_sel_t adv_sel;
    logic       count_inc;
    logic       emit_match;
    logic       emit_sum;
    logic       cfg_wr;
  } bcs_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic at_end;
    logic eot;
    logic scan_v;
    logic scan_eq;
    logic scan_last;
    logic skip_zero;
    logic skip_near;
    logic m_one;
    logic out_free;
  } bcs_sts_t;

endpackage

/* sv/bcs_ctrl.sv */
// Sequencing state machine of the bad-character skip search core.
module bcs_ctrl
  import bcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_opcode,
  input  logic     in_end_of_text,
  input  logic     cfg_valid,
  input  bcs_sts_t sts_i,
  output logic     in_stall,
  output logic     cfg_ready,
  output bcs_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CMP    = 6'b000010,
    ST_SKIP   = 6'b000100,
    ST_SRCH   = 6'b001000,
    ST_EMIT_M = 6'b010000,
    ST_EMIT_S = 6'b100000
  } state_t;

  state_t state_r, state_nxt, post_st;

  // Where to go once the window has moved
  assign post_st = sts_i.eot ? ST_EMIT_S : ST_IDLE;

  // Hold input while busy or while a register write is pending
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd_o     = '0;
    cmd_o.adv_sel = SH_ONE;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          cmd_o.cfg_wr = 1'b1;
        end else if (in_valid) begin
          if (in_opcode == OP_LOAD) begin
            cmd_o.acc_load = 1'b1;
          end else begin
            cmd_o.acc_text = 1'b1;
            if (sts_i.at_end) begin
              cmd_o.cmp_start = 1'b1;
              state_nxt = ST_CMP;
            end else if (in_end_of_text) begin
              state_nxt = ST_EMIT_S;
            end
          end
        end
      end
      ST_CMP: begin
        // Right-to-left compare of window against pattern
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_v && !sts_i.scan_eq) begin
          state_nxt = ST_SKIP;
        end else if (sts_i.scan_v && sts_i.scan_last) begin
          cmd_o.adv       = 1'b1;
          cmd_o.adv_sel   = SH_ONE;
          cmd_o.count_inc = 1'b1;
          state_nxt = ST_EMIT_M;
        end
      end
      ST_SKIP: begin
        // Pick the shift from the skip entry of the window end byte
        if (sts_i.skip_zero || sts_i.m_one) begin
          cmd_o.adv     = 1'b1;
          cmd_o.adv_sel = SH_M;
          state_nxt = post_st;
        end else if (sts_i.skip_near) begin
          cmd_o.adv     = 1'b1;
          cmd_o.adv_sel = SH_NEAR;
          state_nxt = post_st;
        end else begin
          cmd_o.srch_start = 1'b1;
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        // Scan pattern bytes m-2 down to 0 for the window end byte
        cmd_o.scan_en   = 1'b1;
        cmd_o.scan_srch = 1'b1;
        if (sts_i.scan_v && sts_i.scan_eq) begin
          cmd_o.adv     = 1'b1;
          cmd_o.adv_sel = SH_FOUND;
          state_nxt = post_st;
        end else if (sts_i.scan_v && sts_i.scan_last) begin
          cmd_o.adv     = 1'b1;
          cmd_o.adv_sel = SH_M;
          state_nxt = post_st;
        end
      end
      ST_EMIT_M: begin
        if (sts_i.out_free) begin
          cmd_o.emit_match = 1'b1;
          state_nxt = post_st;
        end
      end
      ST_EMIT_S: begin
        if (sts_i.out_free) begin
          cmd_o.emit_sum = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Never load the output register over an unread beat
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.emit_match || cmd_o.emit_sum) |-> sts_i.out_free)
    else $error("result emitted while output register busy");

  // A search only runs after a skip decision
  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH) |-> ($past(state_r) == ST_SKIP || $past(state_r) == ST_SRCH))
    else $error("search entered without skip decision");

  // Text that ends no window and no stream returns straight to idle
  a_plain_text: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.acc_text && !sts_i.at_end && !in_end_of_text) |=> (state_r == ST_IDLE))
    else $error("plain text byte left controller busy");

endmodule

/* sv/bcs_dpath.sv */
// Datapath of the bad-character skip search core: stores, scan unit, counters, output register.
module bcs_dpath
  import bcs_pkg::*;
#(
  parameter int PATTERN_MAX   = 64,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bcs_cmd_t          cmd_i,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_end_of_text,
  input  logic [CFG_W-1:0]  cfg_pattern_length,
  input  logic              out_stall,
  output bcs_sts_t          sts_o,
  output logic              out_valid,
  output logic              out_result_kind,
  output logic [CNT_W-1:0]  out_match_offset,
  output logic [CNT_W-1:0]  out_matches_total,
  output logic              out_none_found,
  output logic              out_final_result
);

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int PW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

  // Stores
  logic [BYTE_W-1:0] pat_mem  [PATTERN_MAX];
  logic [BYTE_W-1:0] ring_mem [PATTERN_MAX];
  logic [LW-1:0]     skip_mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] skip_vld_r, skip_vld_nxt;

  // Stream state
  logic [LW-1:0]    m_r, m_cfg;
  logic [LW-1:0]    li_r;
  logic [PW-1:0]    head_r;
  logic [CNT_W-1:0] pos_r, nwe_r, cnt_r;

  // Held text beat
  logic [BYTE_W-1:0] byte_r;
  logic              eot_r;
  logic [LW-1:0]     skip_q_r;
  logic              skip_hit_r;

  // Scan unit
  logic [PW-1:0]     j_r, rp_r, cmp_idx_r;
  logic              iss_done_r, cmp_v_r, cmp_last_r;
  logic [BYTE_W-1:0] pat_q_r, ring_q_r;
  logic              issue;

  logic              in_alpha, load_ok;
  logic [AW-1:0]     a_idx;
  logic [LW-1:0]     shift;
  logic              out_free;

  assign in_alpha = ({1'b0, in_data_byte} < 9'(ALPHABET_SIZE));
  assign a_idx    = in_data_byte[AW-1:0];
  assign load_ok  = cmd_i.acc_load && (li_r != LW'(PATTERN_MAX));
  assign issue    = cmd_i.scan_en && !iss_done_r;
  assign out_free = !out_valid || !out_stall;

  // Clamp the written window length into 1..PATTERN_MAX
  always_comb begin
    if (cfg_pattern_length == '0) begin
      m_cfg = LW'(1);
    end else if (32'(cfg_pattern_length) > 32'(PATTERN_MAX)) begin
      m_cfg = LW'(PATTERN_MAX);
    end else begin
      m_cfg = LW'(cfg_pattern_length);
    end
  end

  // Window advance
  always_comb begin
    case (cmd_i.adv_sel)
      SH_ONE:   shift = LW'(1);
      SH_M:     shift = m_r;
      SH_NEAR:  shift = m_r - skip_q_r;
      SH_FOUND: shift = m_r - LW'(1) - LW'(cmp_idx_r);
      default:  shift = m_r;
    endcase
  end

  // Skip table valid bits: drop all on the first byte of a new pattern
  always_comb begin
    skip_vld_nxt = skip_vld_r;
    if (load_ok) begin
      if (li_r == '0) begin
        skip_vld_nxt = '0;
      end
      if (in_alpha) begin
        skip_vld_nxt[a_idx] = 1'b1;
      end
    end
  end

  // Store writes and registered reads
  always_ff @(posedge clk) begin
    if (load_ok) begin
      pat_mem[li_r[PW-1:0]] <= in_data_byte;
    end
    if (load_ok && in_alpha) begin
      skip_mem[a_idx] <= li_r + LW'(1);
    end
    if (cmd_i.acc_text) begin
      ring_mem[head_r] <= in_data_byte;
      skip_q_r   <= skip_mem[a_idx];
      skip_hit_r <= in_alpha && skip_vld_r[a_idx];
      byte_r     <= in_data_byte;
      eot_r      <= in_end_of_text;
    end
    if (issue) begin
      pat_q_r    <= pat_mem[j_r];
      ring_q_r   <= ring_mem[rp_r];
      cmp_idx_r  <= j_r;
      cmp_last_r <= (j_r == '0);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_vld_r <= '0;
      m_r        <= LW'(1);
      li_r       <= '0;
      head_r     <= '0;
      pos_r      <= '0;
      nwe_r      <= '0;
      cnt_r      <= '0;
      j_r        <= '0;
      rp_r       <= '0;
      iss_done_r <= 1'b1;
      cmp_v_r    <= 1'b0;
    end else begin
      skip_vld_r <= skip_vld_nxt;
      cmp_v_r    <= issue;

      // Pattern load index
      if (cmd_i.acc_text) begin
        li_r <= '0;
      end else if (load_ok) begin
        li_r <= li_r + LW'(1);
      end

      // Stream position, ring head, window end, count
      if (cmd_i.cfg_wr) begin
        m_r    <= m_cfg;
        pos_r  <= '0;
        nwe_r  <= CNT_W'(m_cfg) - CNT_W'(1);
        cnt_r  <= '0;
        head_r <= '0;
      end else if (cmd_i.emit_sum) begin
        pos_r  <= '0;
        nwe_r  <= CNT_W'(m_r) - CNT_W'(1);
        cnt_r  <= '0;
        head_r <= '0;
      end else begin
        if (cmd_i.acc_text) begin
          pos_r  <= pos_r + CNT_W'(1);
          head_r <= (head_r == PW'(PATTERN_MAX - 1)) ? '0 : head_r + PW'(1);
        end
        if (cmd_i.adv) begin
          nwe_r <= nwe_r + CNT_W'(shift);
        end
        if (cmd_i.count_inc && (cnt_r != '1)) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end

      // Scan address sequencing
      if (cmd_i.cmp_start) begin
        j_r        <= PW'(m_r - LW'(1));
        rp_r       <= head_r;
        iss_done_r <= 1'b0;
      end else if (cmd_i.srch_start) begin
        j_r        <= PW'(m_r - LW'(2));
        iss_done_r <= 1'b0;
      end else if (issue) begin
        j_r  <= j_r - PW'(1);
        rp_r <= (rp_r == '0) ? PW'(PATTERN_MAX - 1) : rp_r - PW'(1);
        if (j_r == '0) begin
          iss_done_r <= 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd_i.emit_match || cmd_i.emit_sum) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit_match) begin
      out_result_kind   <= KIND_MATCH;
      out_match_offset  <= pos_r - CNT_W'(m_r);
      out_matches_total <= cnt_r;
      out_none_found    <= 1'b0;
      out_final_result  <= !eot_r;
    end else if (cmd_i.emit_sum) begin
      out_result_kind   <= KIND_SUMMARY;
      out_match_offset  <= '0;
      out_matches_total <= cnt_r;
      out_none_found    <= (cnt_r == '0);
      out_final_result  <= 1'b1;
    end
  end

  // Status
  always_comb begin
    sts_o           = '0;
    sts_o.at_end    = (pos_r == nwe_r);
    sts_o.eot       = eot_r;
    sts_o.scan_v    = cmp_v_r;
    sts_o.scan_eq   = cmd_i.scan_srch ? (pat_q_r == byte_r) : (pat_q_r == ring_q_r);
    sts_o.scan_last = cmp_last_r;
    sts_o.skip_zero = !skip_hit_r;
    sts_o.skip_near = (skip_q_r < m_r);
    sts_o.m_one     = (m_r == LW'(1));
    sts_o.out_free  = out_free;
  end

  // A match beat always carries a non-zero count
  a_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_MATCH) |-> (out_matches_total != '0))
    else $error("match beat with zero count");

  // A summary beat is final and flags an empty stream consistently
  a_summary: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_SUMMARY) |->
      (out_final_result && out_match_offset == '0 &&
       out_none_found == (out_matches_total == '0)))
    else $error("malformed summary beat");

  // Window length and load index stay within the store
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (m_r != '0) && (32'(m_r) <= 32'(PATTERN_MAX)) && (32'(li_r) <= 32'(PATTERN_MAX)))
    else $error("window length or load index out of range");

endmodule

/* sv/bad_character_skip_search_core.sv */
// Top level of the bad-character skip (Horspool) byte pattern search core.
//
// Pattern bytes are loaded one per input beat (opcode 0); the first load after
// any text byte starts a new pattern and clears the skip table through its
// valid bits. Text bytes (opcode 1) enter a window ring. A text byte that ends
// a window starts a right-to-left compare that reads the pattern store and the
// window ring once per cycle and stops at the first mismatch. A mismatch then
// looks at the skip entry, and where the byte's last load lies at or past the
// window end, scans the pattern store. Each result beat is emitted from its own
// state. The single read port of the pattern store sets the work per byte.
// Results sit in an output register, so new input is taken while a beat waits
// downstream. Write pattern_length only while the core is idle; the write
// restarts the stream.
module bad_character_skip_search_core
  import bcs_pkg::*;
#(
  parameter int PATTERN_MAX   = 64,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_opcode,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_end_of_text,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_result_kind,
  output logic [CNT_W-1:0]  out_match_offset,
  output logic [CNT_W-1:0]  out_matches_total,
  output logic              out_none_found,
  output logic              out_final_result,
  // register write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_pattern_length
);

  bcs_cmd_t cmd;
  bcs_sts_t sts;

  bcs_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_opcode      (in_opcode),
    .in_end_of_text (in_end_of_text),
    .cfg_valid      (cfg_valid),
    .sts_i          (sts),
    .in_stall       (in_stall),
    .cfg_ready      (cfg_ready),
    .cmd_o          (cmd)
  );

  bcs_dpath #(
    .PATTERN_MAX   (PATTERN_MAX),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_i              (cmd),
    .in_data_byte       (in_data_byte),
    .in_end_of_text     (in_end_of_text),
    .cfg_pattern_length (cfg_pattern_length),
    .out_stall          (out_stall),
    .sts_o              (sts),
    .out_valid          (out_valid),
    .out_result_kind    (out_result_kind),
    .out_match_offset   (out_match_offset),
    .out_matches_total  (out_matches_total),
    .out_none_found     (out_none_found),
    .out_final_result   (out_final_result)
  );

endmodule
